>>> rtl/core/fpd_pkg.sv
// ============================================================================
// fpd_pkg
// shared types, constants and the crc-16 ccitt byte update for the decoder
// ============================================================================
package fpd_pkg;

    localparam int MAX_PAYLOAD_DEF = 1024;

    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 16;
    localparam int INDEX_W   = 10;
    localparam int PLEN_W    = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [WORD_W-1:0] HEADER_RST = 16'h8668;
    localparam logic [WORD_W-1:0] FOOTER_RST = 16'h55AA;
    localparam logic [WORD_W-1:0] CRC_POLY   = 16'h1021;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADER = 1'b0,
        REG_FOOTER = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_INCOMPLETE = 2'd0,
        ST_BAD_LEN    = 2'd1,
        ST_BAD_FOOTER = 2'd2,
        ST_FRAME_OK   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CRC_NONE  = 2'd0,
        CRC_START = 2'd1,
        CRC_CONT  = 2'd2
    } t_crc_op;

    typedef struct packed {
        t_status             status;
        t_crc_op             crc_op;
        logic                check;
        logic [WORD_W-1:0]   rx_crc;
        logic [BYTE_W-1:0]   data;
        logic                payload_valid;
        logic [INDEX_W-1:0]  payload_index;
        logic [BYTE_W-1:0]   packet_type;
        logic [PLEN_W-1:0]   payload_length;
    } t_cmd;

    typedef struct packed {
        t_status             status;
        logic                payload_valid;
        logic [BYTE_W-1:0]   payload_byte;
        logic [INDEX_W-1:0]  payload_index;
        logic [BYTE_W-1:0]   packet_type;
        logic [PLEN_W-1:0]   payload_length;
        logic                crc_ok;
    } t_result;

    function automatic logic [WORD_W-1:0] crc_step(input logic [WORD_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
        logic [WORD_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[WORD_W-1]) begin
                c = {c[WORD_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[WORD_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/core/fpd_fifo.sv
// ============================================================================
// fpd_fifo
// small register queue with count based full and empty flags
// ============================================================================
module fpd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == CNT_FULL);
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!w_do_push && w_do_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> rtl/core/fpd_front.sv
// ============================================================================
// fpd_front
// header hunt, frame position tracking and per-byte classification
// ============================================================================
module fpd_front
    import fpd_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data,
    input  logic                 i_accept,
    input  logic [BYTE_W-1:0]    i_byte,
    output t_cmd                 o_cmd
);

    localparam int POS_W = $clog2(MAX_PAYLOAD + 9);
    localparam int LEN_W = $clog2(MAX_PAYLOAD + 4);
    localparam logic [WORD_W-1:0] LEN_MIN = WORD_W'(3);
    localparam logic [WORD_W-1:0] LEN_MAX = WORD_W'(MAX_PAYLOAD + 3);
    localparam logic [LEN_W-1:0]  LEN_OFS = LEN_W'(3);
    localparam logic [POS_W-1:0]  P2 = POS_W'(2);
    localparam logic [POS_W-1:0]  P3 = POS_W'(3);
    localparam logic [POS_W-1:0]  P4 = POS_W'(4);
    localparam logic [POS_W-1:0]  P5 = POS_W'(5);

    logic [WORD_W-1:0] r_header;
    logic [WORD_W-1:0] r_footer;
    logic [POS_W-1:0]  r_pos,     n_pos;
    logic              r_prefix,  n_prefix;
    logic [BYTE_W-1:0] r_len_hi,  n_len_hi;
    logic [LEN_W-1:0]  r_len,     n_len;
    logic [WORD_W-1:0] r_rx,      n_rx;
    logic [BYTE_W-1:0] r_type,    n_type;
    logic [BYTE_W-1:0] r_foot_hi, n_foot_hi;

    logic [WORD_W-1:0]        w_len16;
    logic [WORD_W-1:0]        w_foot;
    logic [POS_W-1:0]         w_len_pos;
    logic [POS_W-1:0]         w_idx;
    logic [POS_W+INDEX_W-1:0] w_idx_pad;
    logic [LEN_W-1:0]         w_plen;
    logic [LEN_W+PLEN_W-1:0]  w_plen_pad;

    assign w_len16    = {r_len_hi, i_byte};
    assign w_foot     = {r_foot_hi, i_byte};
    assign w_len_pos  = POS_W'(r_len);
    assign w_idx      = r_pos - P5;
    assign w_idx_pad  = {{INDEX_W{1'b0}}, w_idx};
    assign w_plen     = (n_len >= LEN_OFS) ? (n_len - LEN_OFS) : '0;
    assign w_plen_pad = {{PLEN_W{1'b0}}, w_plen};

    always_comb begin
        n_pos     = r_pos;
        n_prefix  = r_prefix;
        n_len_hi  = r_len_hi;
        n_len     = r_len;
        n_rx      = r_rx;
        n_type    = r_type;
        n_foot_hi = r_foot_hi;

        o_cmd               = '0;
        o_cmd.status        = ST_INCOMPLETE;
        o_cmd.crc_op        = CRC_NONE;
        o_cmd.data          = i_byte;

        if (r_pos == '0) begin
            if (r_prefix && (i_byte == r_header[7:0])) begin
                n_pos    = P2;
                n_prefix = 1'b0;
            end else begin
                n_prefix = (i_byte == r_header[15:8]);
            end
        end else begin
            n_pos = r_pos + POS_W'(1);
            if (r_pos == P2) begin
                n_len_hi     = i_byte;
                o_cmd.crc_op = CRC_START;
            end else if (r_pos == P3) begin
                if ((w_len16 < LEN_MIN) || (w_len16 > LEN_MAX)) begin
                    n_pos        = '0;
                    n_len_hi     = '0;
                    n_foot_hi    = '0;
                    n_rx         = '0;
                    n_prefix     = (i_byte == r_header[15:8]);
                    o_cmd.status = ST_BAD_LEN;
                end else begin
                    n_len        = LEN_W'(w_len16);
                    o_cmd.crc_op = CRC_CONT;
                end
            end else begin
                if (r_pos == P4) begin
                    n_type       = i_byte;
                    o_cmd.crc_op = CRC_CONT;
                end else if (r_pos < w_len_pos + P2) begin
                    o_cmd.payload_valid = 1'b1;
                    o_cmd.payload_index = w_idx_pad[INDEX_W-1:0];
                    o_cmd.crc_op        = CRC_CONT;
                end else if (r_pos == w_len_pos + P2) begin
                    n_rx = {i_byte, 8'h00};
                end else if (r_pos == w_len_pos + P3) begin
                    n_rx = r_rx | {8'h00, i_byte};
                end else if (r_pos == w_len_pos + P4) begin
                    n_foot_hi = i_byte;
                end
                if (r_pos >= w_len_pos + P5) begin
                    if ((r_pos != w_len_pos + P5) || (w_foot != r_footer)) begin
                        n_pos        = '0;
                        n_len_hi     = '0;
                        n_foot_hi    = '0;
                        n_rx         = '0;
                        n_prefix     = (i_byte == r_header[15:8]);
                        o_cmd.status = ST_BAD_FOOTER;
                        if (w_foot == r_header) begin
                            n_pos    = P2;
                            n_prefix = 1'b0;
                        end
                    end else begin
                        o_cmd.check  = 1'b1;
                        o_cmd.rx_crc = r_rx;
                        n_pos        = '0;
                        n_len_hi     = '0;
                        n_foot_hi    = '0;
                        n_rx         = '0;
                        n_prefix     = 1'b0;
                        o_cmd.status = ST_FRAME_OK;
                    end
                end
            end
        end

        o_cmd.packet_type    = n_type;
        o_cmd.payload_length = w_plen_pad[PLEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header  <= HEADER_RST;
            r_footer  <= FOOTER_RST;
            r_pos     <= '0;
            r_prefix  <= 1'b0;
            r_len_hi  <= '0;
            r_len     <= '0;
            r_rx      <= '0;
            r_type    <= '0;
            r_foot_hi <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    REG_HEADER: r_header <= i_cfg_data;
                    REG_FOOTER: r_footer <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_accept) begin
                r_pos     <= n_pos;
                r_prefix  <= n_prefix;
                r_len_hi  <= n_len_hi;
                r_len     <= n_len;
                r_rx      <= n_rx;
                r_type    <= n_type;
                r_foot_hi <= n_foot_hi;
            end
        end
    end

    // a completed frame always returns to the hunt
    a_done_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (o_cmd.status == ST_FRAME_OK)) |=> (r_pos == '0))
        else $error("frame complete did not return to hunt");

    // a length error is only raised on the length low byte
    a_len_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (o_cmd.status == ST_BAD_LEN)) |-> (r_pos == P3))
        else $error("length error outside length field");

    // no payload transfer while hunting
    a_hunt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (r_pos == '0)) |-> !o_cmd.payload_valid)
        else $error("payload byte flagged while hunting");

endmodule

>>> rtl/core/fpd_back.sv
// ============================================================================
// fpd_back
// crc-16 ccitt accumulation and result formation from classified bytes
// ============================================================================
module fpd_back
    import fpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_empty,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    input  logic    i_res_full,
    output logic    o_res_push,
    output t_result o_res
);

    logic [WORD_W-1:0] r_crc;
    logic [WORD_W-1:0] n_crc;
    logic              w_go;

    assign w_go       = !i_cmd_empty && !i_res_full;
    assign o_cmd_pop  = w_go;
    assign o_res_push = w_go;

    always_comb begin
        unique case (i_cmd.crc_op)
            CRC_START: n_crc = crc_step('0, i_cmd.data);
            CRC_CONT:  n_crc = crc_step(r_crc, i_cmd.data);
            default:   n_crc = r_crc;
        endcase
    end

    always_comb begin
        o_res.status         = i_cmd.status;
        o_res.payload_valid  = i_cmd.payload_valid;
        o_res.payload_byte   = i_cmd.payload_valid ? i_cmd.data : '0;
        o_res.payload_index  = i_cmd.payload_index;
        o_res.packet_type    = i_cmd.packet_type;
        o_res.payload_length = i_cmd.payload_length;
        o_res.crc_ok         = i_cmd.check && (i_cmd.rx_crc == r_crc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= '0;
        end else if (w_go) begin
            r_crc <= n_crc;
        end
    end

    // crc_ok is only reported with a complete frame
    a_crc_ok_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && o_res.crc_ok) |-> (o_res.status == ST_FRAME_OK))
        else $error("crc_ok set without frame complete");

endmodule

>>> rtl/core/framed_packet_decoder.sv
// ============================================================================
// framed_packet_decoder
// byte stream frame decoder with crc-16 ccitt check and payload streaming
// ============================================================================
// Takes one received byte per transfer and returns exactly one result per
// byte, in order. The decoder accepts a byte every clock cycle while results
// are popped. The front stage resolves the frame position and the back stage
// runs one full crc byte update per cycle while it has a byte and room for a
// result. A two-entry queue sits between them, and a second two-entry queue
// holds results until popped. A byte's result goes through the command queue
// and the back stage into the result queue on its way to the result ports.
// With pop held low the input side reports full after four bytes.
// Header and footer markers are written through the configuration channel,
// which is always ready; index 0 is the header and index 1 the footer.
module framed_packet_decoder
    import fpd_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [BYTE_W-1:0]    i_in_byte,
    output logic                 empty,
    input  logic                 pop,
    output logic [1:0]           o_status,
    output logic                 o_payload_valid,
    output logic [BYTE_W-1:0]    o_payload_byte,
    output logic [INDEX_W-1:0]   o_payload_index,
    output logic [BYTE_W-1:0]    o_packet_type,
    output logic [PLEN_W-1:0]    o_payload_length,
    output logic                 o_crc_ok,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    localparam int CMD_W = $bits(t_cmd);
    localparam int RES_W = $bits(t_result);

    logic             w_accept;
    t_cmd             w_front_cmd;
    logic             w_cmd_full;
    logic             w_cmd_empty;
    logic [CMD_W-1:0] w_cmd_data;
    t_cmd             w_back_cmd;
    logic             w_cmd_pop;
    logic             w_res_full;
    logic             w_res_push;
    t_result          w_back_res;
    logic [RES_W-1:0] w_res_data;
    t_result          w_out;

    assign o_cfg_ready = 1'b1;
    assign full        = w_cmd_full;
    assign w_accept    = push && !w_cmd_full;

    fpd_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_accept),
        .i_byte      (i_in_byte),
        .o_cmd       (w_front_cmd)
    );

    fpd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_front_cmd),
        .o_full  (w_cmd_full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_data),
        .o_empty (w_cmd_empty)
    );

    assign w_back_cmd = t_cmd'(w_cmd_data);

    fpd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (w_cmd_empty),
        .i_cmd       (w_back_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_back_res)
    );

    fpd_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_back_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_data),
        .o_empty (empty)
    );

    assign w_out            = t_result'(w_res_data);
    assign o_status         = 2'(w_out.status);
    assign o_payload_valid  = w_out.payload_valid;
    assign o_payload_byte   = w_out.payload_byte;
    assign o_payload_index  = w_out.payload_index;
    assign o_packet_type    = w_out.packet_type;
    assign o_payload_length = w_out.payload_length;
    assign o_crc_ok         = w_out.crc_ok;

endmodule

>>> sim/framed_packet_decoder_test.sv
// ============================================================================
// framed_packet_decoder_test
// self-checking testbench for the framed packet decoder
// ============================================================================
// Feeds byte streams of framed packets into the decoder and checks every
// per-byte result against a bit-accurate decoder model kept in the bench.
// Directed frames cover a good frame, crc mismatch, bad length and a bad
// footer that doubles as a new header. Random traffic then mixes good and
// broken frames with noise under several marker settings and idle
// patterns, followed by a maximum-size payload and an output hold-off.
// ============================================================================
module framed_packet_decoder_test;
    import fpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PAYLOAD = MAX_PAYLOAD_DEF;

    typedef logic [BYTE_W-1:0] t_byte_q [$];

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic [BYTE_W-1:0]    i_in_byte = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [1:0]           o_status;
    logic                 o_payload_valid;
    logic [BYTE_W-1:0]    o_payload_byte;
    logic [INDEX_W-1:0]   o_payload_index;
    logic [BYTE_W-1:0]    o_packet_type;
    logic [PLEN_W-1:0]    o_payload_length;
    logic                 o_crc_ok;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    t_cfg_reg             i_cfg_index = REG_HEADER;
    logic [WORD_W-1:0]    i_cfg_data = '0;

    // decoder model state
    logic [WORD_W-1:0]    hdr_word;
    logic [WORD_W-1:0]    ftr_word;
    int                   frame_pos;
    logic                 prefix_seen;
    logic [BYTE_W-1:0]    len_hi;
    logic [PLEN_W-1:0]    frame_len;
    logic [WORD_W-1:0]    crc_acc;
    logic [WORD_W-1:0]    crc_rx;
    logic [BYTE_W-1:0]    frame_kind;
    logic [BYTE_W-1:0]    foot_hi;

    t_result              decoded_q [$];
    t_byte_q              payload_bytes;
    t_byte_q              frame_bytes;

    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    int                   hold_cycles = 0;
    int                   sent_count = 0;
    int                   error_count = 0;

    framed_packet_decoder #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_in_byte       (i_in_byte),
        .empty           (empty),
        .pop             (pop),
        .o_status        (o_status),
        .o_payload_valid (o_payload_valid),
        .o_payload_byte  (o_payload_byte),
        .o_payload_index (o_payload_index),
        .o_packet_type   (o_packet_type),
        .o_payload_length(o_payload_length),
        .o_crc_ok        (o_crc_ok),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [WORD_W-1:0] crc16_ccitt_byte(input logic [WORD_W-1:0] acc,
                                                           input logic [BYTE_W-1:0] data);
        logic fb;
        for (int k = BYTE_W - 1; k >= 0; k--) begin
            fb  = acc[WORD_W-1] ^ data[k];
            acc = {acc[WORD_W-2:0], 1'b0};
            if (fb) begin
                acc = acc ^ 16'h1021;
            end
        end
        return acc;
    endfunction

    function automatic void clear_frame();
        frame_pos   = 0;
        len_hi      = '0;
        foot_hi     = '0;
        crc_acc     = '0;
        crc_rx      = '0;
        prefix_seen = 1'b0;
    endfunction

    function automatic void restart_hunt(input logic [BYTE_W-1:0] b);
        clear_frame();
        prefix_seen = (b == hdr_word[15:8]);
    endfunction

    function automatic void decoder_reset();
        hdr_word   = HEADER_RST;
        ftr_word   = FOOTER_RST;
        clear_frame();
        frame_len  = '0;
        frame_kind = '0;
    endfunction

    function automatic t_result predict_result(input logic [BYTE_W-1:0] b);
        t_result           r;
        int                p;
        logic [WORD_W-1:0] len;
        logic [WORD_W-1:0] foot;
        logic              fresh;
        r = '0;
        r.status = ST_INCOMPLETE;
        if (frame_pos == 0) begin
            if (prefix_seen && b == hdr_word[7:0]) begin
                frame_pos   = 2;
                prefix_seen = 1'b0;
            end else begin
                prefix_seen = (b == hdr_word[15:8]);
            end
        end else begin
            p = frame_pos;
            frame_pos = p + 1;
            if (p == 2) begin
                len_hi  = b;
                crc_acc = crc16_ccitt_byte(crc_acc, b);
            end else if (p == 3) begin
                len = {len_hi, b};
                if (len < 3 || len > MAX_PAYLOAD + 3) begin
                    restart_hunt(b);
                    r.status = ST_BAD_LEN;
                end else begin
                    frame_len = len[PLEN_W-1:0];
                    crc_acc   = crc16_ccitt_byte(crc_acc, b);
                end
            end else begin
                if (p == 4) begin
                    frame_kind = b;
                    crc_acc    = crc16_ccitt_byte(crc_acc, b);
                end else if (p < frame_len + 2) begin
                    r.payload_valid = 1'b1;
                    r.payload_byte  = b;
                    r.payload_index = INDEX_W'(p - 5);
                    crc_acc         = crc16_ccitt_byte(crc_acc, b);
                end else if (p == frame_len + 2) begin
                    crc_rx = {b, 8'h00};
                end else if (p == frame_len + 3) begin
                    crc_rx[7:0] = b;
                end else if (p == frame_len + 4) begin
                    foot_hi = b;
                end
                if (p >= frame_len + 5) begin
                    foot = {foot_hi, b};
                    if (p != frame_len + 5 || foot != ftr_word) begin
                        fresh = (foot == hdr_word);
                        restart_hunt(b);
                        if (fresh) begin
                            frame_pos   = 2;
                            prefix_seen = 1'b0;
                        end
                        r.status = ST_BAD_FOOTER;
                    end else begin
                        r.crc_ok = (crc_rx == crc_acc);
                        clear_frame();
                        r.status = ST_FRAME_OK;
                    end
                end
            end
        end
        r.packet_type    = frame_kind;
        r.payload_length = (frame_len >= PLEN_W'(3)) ? frame_len - PLEN_W'(3) : '0;
        return r;
    endfunction

    // header, length, type, payload_bytes, crc, footer into frame_bytes
    function automatic void build_frame(input logic [BYTE_W-1:0] kind,
                                        input logic [WORD_W-1:0] crc_flip,
                                        input logic [WORD_W-1:0] foot);
        logic [WORD_W-1:0] len;
        logic [WORD_W-1:0] crc;
        len = WORD_W'(payload_bytes.size() + 3);
        crc = crc16_ccitt_byte('0, len[15:8]);
        crc = crc16_ccitt_byte(crc, len[7:0]);
        crc = crc16_ccitt_byte(crc, kind);
        frame_bytes.delete();
        frame_bytes.push_back(hdr_word[15:8]);
        frame_bytes.push_back(hdr_word[7:0]);
        frame_bytes.push_back(len[15:8]);
        frame_bytes.push_back(len[7:0]);
        frame_bytes.push_back(kind);
        foreach (payload_bytes[i]) begin
            crc = crc16_ccitt_byte(crc, payload_bytes[i]);
            frame_bytes.push_back(payload_bytes[i]);
        end
        crc = crc ^ crc_flip;
        frame_bytes.push_back(crc[15:8]);
        frame_bytes.push_back(crc[7:0]);
        frame_bytes.push_back(foot[15:8]);
        frame_bytes.push_back(foot[7:0]);
    endfunction

    function automatic void fill_payload(input int count);
        payload_bytes.delete();
        repeat (count) payload_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
    endfunction

    // called just after a falling edge, returns just after a falling edge
    task automatic send_byte(input logic [BYTE_W-1:0] value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push      <= 1'b1;
        i_in_byte <= value;
        do @(posedge i_clk); while (full);
        decoded_q.push_back(predict_result(value));
        @(negedge i_clk);
    endtask

    task automatic send_span(input int first, input int stop);
        for (int i = first; i < stop; i++) begin
            send_byte(frame_bytes[i]);
        end
        sent_count += stop - first;
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        do @(negedge i_clk); while (decoded_q.size() != 0);
    endtask

    task automatic set_markers(input logic [WORD_W-1:0] hdr, input logic [WORD_W-1:0] ftr);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_HEADER;
        i_cfg_data  <= hdr;
        do @(posedge i_clk); while (!o_cfg_ready);
        hdr_word = hdr;
        @(negedge i_clk);
        i_cfg_index <= REG_FOOTER;
        i_cfg_data  <= ftr;
        do @(posedge i_clk); while (!o_cfg_ready);
        ftr_word = ftr;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_frame(input int plen);
        int                r;
        logic [WORD_W-1:0] flip;
        logic [WORD_W-1:0] foot;
        logic [WORD_W-1:0] bad_len;
        if ($urandom_range(0, 99) < 20) begin
            repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom_range(0, 255)));
        end
        fill_payload(plen);
        flip = '0;
        foot = ftr_word;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            flip = WORD_W'($urandom_range(1, 65535));
        end else if (r < 25) begin
            if ($urandom_range(0, 1) && hdr_word != ftr_word) begin
                foot = hdr_word;
            end else begin
                foot = ftr_word ^ WORD_W'($urandom_range(1, 65535));
            end
        end
        build_frame(BYTE_W'($urandom_range(0, 255)), flip, foot);
        if (r >= 25 && r < 35) begin
            if ($urandom_range(0, 1)) begin
                bad_len = WORD_W'($urandom_range(0, 2));
            end else begin
                bad_len = WORD_W'($urandom_range(MAX_PAYLOAD + 4, 65535));
            end
            frame_bytes[2] = bad_len[15:8];
            frame_bytes[3] = bad_len[7:0];
            send_span(0, 4);
        end else if (r >= 35 && r < 45) begin
            send_span(0, $urandom_range(3, frame_bytes.size() - 1));
        end else begin
            send_span(0, frame_bytes.size());
        end
    endtask

    function automatic int random_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(0, 8);
        end else if (r < 95) begin
            return $urandom_range(9, 64);
        end
        return $urandom_range(65, 200);
    endfunction

    task automatic test_directed_frames();
        payload_bytes.delete();
        build_frame(8'hFF, 16'h0000, ftr_word);
        send_span(0, frame_bytes.size());
        // footer equal to the header opens the next frame
        payload_bytes = {8'h00};
        build_frame(8'h00, 16'h0000, hdr_word);
        send_span(0, frame_bytes.size());
        payload_bytes = {8'hFF};
        build_frame(8'h5A, 16'h8001, ftr_word);
        send_span(2, frame_bytes.size());
        // bad length whose low byte restarts the header, then length 1028
        frame_bytes = {hdr_word[15:8], hdr_word[7:0], 8'hFF, hdr_word[15:8], hdr_word[7:0],
                       8'h04, 8'h04};
        send_span(0, frame_bytes.size());
    endtask

    task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                       input logic [WORD_W-1:0] hdr,
                                       input logic [WORD_W-1:0] ftr, input int count);
        int target;
        wait_drained();
        set_markers(hdr, ftr);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        target = sent_count + count;
        while (sent_count < target) random_frame(random_length());
    endtask

    task automatic test_max_payload();
        wait_drained();
        send_idle_pct  = 30;
        recv_stall_pct = 30;
        fill_payload(MAX_PAYLOAD);
        build_frame(BYTE_W'($urandom_range(0, 255)), 16'h0000, ftr_word);
        send_span(0, frame_bytes.size());
    endtask

    task automatic test_backpressure();
        int target;
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 300;
        target = sent_count + 40;
        while (sent_count < target) random_frame($urandom_range(0, 8));
        wait_drained();
        fill_payload(4);
        build_frame(BYTE_W'($urandom_range(0, 255)), 16'h0000, ftr_word);
        send_span(0, frame_bytes.size());
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    task automatic check_result();
        t_result want;
        if (decoded_q.size() == 0) begin
            error_count++;
            $display("%0t: result with nothing expected, expected none, actual status %0h",
                     $time, o_status);
        end else begin
            want = decoded_q.pop_front();
            check_field("status", WORD_W'(want.status), WORD_W'(o_status));
            check_field("payload_valid", WORD_W'(want.payload_valid),
                        WORD_W'(o_payload_valid));
            check_field("payload_byte", WORD_W'(want.payload_byte), WORD_W'(o_payload_byte));
            check_field("payload_index", WORD_W'(want.payload_index),
                        WORD_W'(o_payload_index));
            check_field("packet_type", WORD_W'(want.packet_type), WORD_W'(o_packet_type));
            check_field("payload_length", WORD_W'(want.payload_length),
                        WORD_W'(o_payload_length));
            check_field("crc_ok", WORD_W'(want.crc_ok), WORD_W'(o_crc_ok));
        end
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
            end
        end
    end

    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            pop <= (hold_cycles == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
            @(posedge i_clk);
            if (pop && !empty) begin
                check_result();
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        decoder_reset();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_frames();
        test_random_traffic(0, 0, 16'h0000, 16'hFFFF, 30);
        test_random_traffic(83, 0, 16'hFFFF, 16'h0000, 30);
        test_random_traffic(0, 83, WORD_W'($urandom_range(0, 65535)),
                            WORD_W'($urandom_range(0, 65535)), 30);
        test_random_traffic(30, 30, 16'hC3C3, 16'hC3C3, 30);
        test_max_payload();
        test_backpressure();
        wait_drained();
        repeat (8) @(negedge i_clk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
